// ===== design/scrolling_test_pattern_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Scrolling test pattern generator: assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_TEST_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define SCROLLING_TEST_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define STPG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stpg: same-cycle check failed");

// next-cycle implication
`define STPG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stpg: next-cycle check failed");

`endif

// ===== design/stpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Scrolling test pattern generator: package
// Types, register codes and constants shared by the generator modules.
// ----------------------------------------------------------------------------
package stpg_pkg;

	localparam int COL_W = 12;
	localparam logic [12:0] MAX_WIDTH = 13'd4095;
	localparam int STRIPE_COUNT = 10;
	localparam int MOD_NUM_W = 13;
	localparam int DIV_NUM_W = 28;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int W10_SHIFT = 20;
	localparam logic [20:0] W10_RECIP = 21'((1 << W10_SHIFT) / STRIPE_COUNT + 1);

	localparam logic [1:0] FMT_GRAY = 2'd0;
	localparam logic [1:0] FMT_RGB  = 2'd1;
	localparam logic [1:0] FMT_BGR  = 2'd2;

	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] REG_WIDTH_PIXELS = 2'd1;
	localparam logic [1:0] REG_HEIGHT_LINES = 2'd2;
	localparam logic [1:0] REG_SCROLL_STEP  = 2'd3;

	localparam logic [1:0]  FMT_RST    = FMT_RGB;
	localparam logic [11:0] WIDTH_RST  = 12'd640;
	localparam logic [11:0] HEIGHT_RST = 12'd480;
	localparam logic [5:0]  STEP_RST   = 6'd2;
	localparam logic [11:0] W10_RST    = 12'(640 / STRIPE_COUNT);

	localparam logic [16:0] Q_ONE = 17'd65536;
	localparam logic [16:0] Q_T1  = 17'd21850;
	localparam logic [16:0] Q_T2  = 17'd43693;

	typedef struct packed {
		logic [1:0]  fmt;
		logic [11:0] width;
		logic [11:0] height;
		logic [11:0] w10;
		logic [5:0]  step;
	} cfg_t;

	typedef struct packed {
		logic [11:0] col;
		logic        eol;
		logic        eof;
	} pix_item_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MOD_COL,
		F_MOD_OFF,
		F_EMIT,
		F_MOD_ADV
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MOD,
		B_SCALE,
		B_DIV,
		B_PUT
	} back_state_t;

endpackage

// ===== design/stpg_div.sv =====
// ----------------------------------------------------------------------------
// Scrolling test pattern generator: iterative divider
// Restoring division, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
module stpg_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);
	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_dif;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den};
	assign rem_dif = rem_sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== design/stpg_fifo.sv =====
// ----------------------------------------------------------------------------
// Scrolling test pattern generator: request queue
// Short FIFO that decouples the position front end from the pixel back end.
// ----------------------------------------------------------------------------
module stpg_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  stpg_pkg::pix_item_t push_item,
	output logic                full,
	input  logic                pop,
	output stpg_pkg::pix_item_t pop_item,
	output logic                empty
);
	import stpg_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pix_item_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== design/stpg_front.sv =====
// ----------------------------------------------------------------------------
// Scrolling test pattern generator: position front end
// Accept requests, track column, row and scroll offset, queue source columns.
// ----------------------------------------------------------------------------
module stpg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  stpg_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                restart,
	output logic                push,
	output stpg_pkg::pix_item_t push_item,
	input  logic                q_full
);
	import stpg_pkg::*;

	front_state_t state_q, state_d;
	logic [11:0]  col_q, col_d;
	logic [11:0]  row_q, row_d;
	logic [11:0]  off_q, off_d;
	logic [11:0]  colm_q;
	logic [11:0]  offm_q;
	logic [11:0]  den_q;

	logic         accept;
	logic [11:0]  col_n, row_n, off_n;
	logic         fast_ok;
	logic         is_emit;
	logic [11:0]  e_col, e_row, e_colm, e_offm;
	logic [12:0]  csum;
	logic [12:0]  col_inc, row_inc;
	logic         eol, eof;
	logic [12:0]  adv, adv_red;
	logic         adv_slow;
	logic [11:0]  col_nx, row_nx, off_nx;

	logic         div_start;
	logic [12:0]  div_num;
	logic         div_done;
	logic [11:0]  div_rem;

	stpg_div #(
		.NUM_W(MOD_NUM_W),
		.DEN_W(COL_W)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (den_q),
		.done  (div_done),
		.quo   (),
		.rem   (div_rem)
	);

	assign in_stall = (state_q != F_IDLE) || q_full;
	assign accept   = in_valid && !in_stall;

	assign col_n   = restart ? '0 : col_q;
	assign row_n   = restart ? '0 : row_q;
	assign off_n   = restart ? {6'b0, cfg.step} : off_q;
	assign fast_ok = (col_n < cfg.width) && (off_n < cfg.width);

	assign is_emit = state_q == F_EMIT;
	assign e_col   = is_emit ? col_q : col_n;
	assign e_row   = is_emit ? row_q : row_n;
	assign e_colm  = is_emit ? colm_q : col_n;
	assign e_offm  = is_emit ? offm_q : off_n;

	assign csum    = {1'b0, e_colm} + {1'b0, e_offm};
	assign col_inc = {1'b0, e_col} + 13'd1;
	assign row_inc = {1'b0, e_row} + 13'd1;
	assign eol     = col_inc >= {1'b0, cfg.width};
	assign eof     = eol && (row_inc >= {1'b0, cfg.height});

	assign adv      = {1'b0, e_offm} + {7'b0, cfg.step};
	assign adv_red  = (adv >= {1'b0, cfg.width}) ? adv - {1'b0, cfg.width} : adv;
	assign adv_slow = eof && (adv_red >= {1'b0, cfg.width});

	assign col_nx = eol ? '0 : col_inc[11:0];
	assign row_nx = eol ? (eof ? '0 : row_inc[11:0]) : e_row;
	assign off_nx = eof ? adv_red[11:0] : e_offm;

	always_comb begin
		push_item.col = (csum >= {1'b0, cfg.width}) ? 12'(csum - {1'b0, cfg.width})
			: csum[11:0];
		push_item.eol = eol;
		push_item.eof = eof;
	end

	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		off_d     = off_q;
		div_start = 1'b0;
		div_num   = '0;
		push      = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (fast_ok) begin
						push  = 1'b1;
						col_d = col_nx;
						row_d = row_nx;
						off_d = off_nx;
						if (adv_slow) begin
							div_start = 1'b1;
							div_num   = adv_red;
							state_d   = F_MOD_ADV;
						end
					end else begin
						col_d     = col_n;
						row_d     = row_n;
						off_d     = off_n;
						div_start = 1'b1;
						div_num   = {1'b0, col_n};
						state_d   = F_MOD_COL;
					end
				end
			end
			F_MOD_COL: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = {1'b0, off_q};
					state_d   = F_MOD_OFF;
				end
			end
			F_MOD_OFF: begin
				if (div_done) state_d = F_EMIT;
			end
			F_EMIT: begin
				push  = 1'b1;
				col_d = col_nx;
				row_d = row_nx;
				off_d = off_nx;
				if (adv_slow) begin
					div_start = 1'b1;
					div_num   = adv_red;
					state_d   = F_MOD_ADV;
				end else begin
					state_d = F_IDLE;
				end
			end
			F_MOD_ADV: begin
				if (div_done) begin
					off_d   = div_rem;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			off_q   <= {6'b0, STEP_RST};
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			off_q   <= off_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) den_q <= cfg.width;
		if (state_q == F_MOD_COL && div_done) colm_q <= div_rem;
		if (state_q == F_MOD_OFF && div_done) offm_q <= div_rem;
	end

endmodule

// ===== design/stpg_back.sv =====
// ----------------------------------------------------------------------------
// Scrolling test pattern generator: pixel back end
// Turn a source column into gray stripes, a hue ramp or black for an unused format; hold the result.
// ----------------------------------------------------------------------------
module stpg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  stpg_pkg::cfg_t      cfg,
	input  logic                q_empty,
	output logic                pop,
	input  stpg_pkg::pix_item_t pop_item,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          chan_a,
	output logic [7:0]          chan_b,
	output logic [7:0]          chan_c,
	output logic                end_of_line,
	output logic                end_of_frame
);
	import stpg_pkg::*;

	back_state_t state_q, state_d;
	pix_item_t   item_q;
	logic        out_valid_q;
	logic [7:0]  chan_a_q, chan_b_q, chan_c_q;
	logic        eol_q, eof_q;

	logic        out_free;
	logic        load;
	logic        div_start;
	logic [27:0] div_num;
	logic [11:0] div_den;
	logic        div_done;
	logic [27:0] div_quo;
	logic [11:0] div_rem;
	logic [19:0] scaled;

	logic [15:0] v;
	logic [17:0] v3;
	logic [17:0] r_x, g_x, b_x;
	logic [7:0]  r_c, g_c, b_c;
	logic [7:0]  a_d, b_d, c_d;

	function automatic logic [17:0] mul3(input logic [16:0] x);
		return {1'b0, x} + {x, 1'b0};
	endfunction

	function automatic logic [9:0] term(input logic [17:0] x);
		logic [25:0] prod;
		prod = {x, 8'b0} - {8'b0, x};
		return prod[25:16];
	endfunction

	function automatic logic [7:0] squash(input logic [9:0] t);
		return (t > 10'd127) ? 8'd254 : {t[6:0], 1'b0};
	endfunction

	stpg_div #(
		.NUM_W(DIV_NUM_W),
		.DEN_W(COL_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	assign div_den  = (state_q == B_MOD || state_q == B_SCALE) ? cfg.w10 : cfg.width;
	assign scaled   = {div_rem, 8'b0} - {8'b0, div_rem};
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					case (cfg.fmt)
						FMT_GRAY: begin
							div_start = 1'b1;
							div_num   = {16'b0, pop_item.col};
							state_d   = B_MOD;
						end
						FMT_RGB, FMT_BGR: begin
							div_start = 1'b1;
							div_num   = {pop_item.col, 16'b0};
							state_d   = B_DIV;
						end
						default: state_d = B_PUT;
					endcase
				end
			end
			B_MOD: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = {8'b0, scaled};
					state_d   = B_SCALE;
				end
			end
			B_SCALE: begin
				if (div_done) state_d = B_PUT;
			end
			B_DIV: begin
				if (div_done) state_d = B_PUT;
			end
			B_PUT: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign v  = div_quo[15:0];
	assign v3 = mul3({1'b0, v});

	always_comb begin
		r_x = '0;
		g_x = '0;
		b_x = '0;
		if ({1'b0, v} < Q_T1) begin
			r_x = (v3 < {1'b0, Q_ONE}) ? {1'b0, Q_ONE} - v3 : '0;
			g_x = v3;
		end else if ({1'b0, v} < Q_T2) begin
			g_x = mul3(Q_T2 - {1'b0, v});
			b_x = mul3({1'b0, v} - Q_T1);
		end else begin
			r_x = mul3({1'b0, v} - Q_T2);
			b_x = mul3(Q_ONE - {1'b0, v});
		end
	end

	assign r_c = squash(term(r_x));
	assign g_c = squash(term(g_x));
	assign b_c = squash(term(b_x));

	always_comb begin
		a_d = '0;
		b_d = '0;
		c_d = '0;
		case (cfg.fmt)
			FMT_GRAY: a_d = div_quo[7:0];
			FMT_RGB: begin
				a_d = r_c;
				b_d = g_c;
				c_d = b_c;
			end
			FMT_BGR: begin
				a_d = b_c;
				b_d = g_c;
				c_d = r_c;
			end
			default: a_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= pop_item;
		if (load) begin
			chan_a_q <= a_d;
			chan_b_q <= b_d;
			chan_c_q <= c_d;
			eol_q    <= item_q.eol;
			eof_q    <= item_q.eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign chan_a       = chan_a_q;
	assign chan_b       = chan_b_q;
	assign chan_c       = chan_c_q;
	assign end_of_line  = eol_q;
	assign end_of_frame = eof_q;

endmodule

// ===== design/scrolling_test_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Scrolling test pattern generator
// Emits one pixel per request in raster order: ten gray sawtooth stripes or
// an RGB/BGR hue ramp, scrolled left by scroll_step pixels every frame.
// A front end tracks column, row and scroll offset and hands the source
// column through a short queue to a back end that forms the pixel with a
// 28-step shared divider. The back end sets the rate: a color pixel takes
// one division and a gray pixel two, with the output register letting the
// next pixel start while one waits to be taken. The front end passes a
// request straight to the queue while it has room; after a width change
// that leaves the column or offset out of range, or a restart with
// scroll_step not below the width, it first reduces them with two divisions,
// and a frame wrap with a very narrow width adds one more.
// ----------------------------------------------------------------------------
`include "scrolling_test_pattern_generator_unit_defines.svh"

module scrolling_test_pattern_generator_unit #(
	parameter int QUEUE_DEPTH = stpg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  chan_a,
	output logic [7:0]  chan_b,
	output logic [7:0]  chan_c,
	output logic        end_of_line,
	output logic        end_of_frame
);
	import stpg_pkg::*;

	logic [1:0]  fmt_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [5:0]  step_q;
	logic [11:0] w10_q;
	logic [11:0] w_eff;
	logic [11:0] h_eff;
	logic [11:0] w10_raw;
	logic [32:0] w10_prod;
	cfg_t        cfg;

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	pix_item_t   push_item;
	pix_item_t   pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			step_q   <= STEP_RST;
			w10_q    <= W10_RST;
		end else begin
			w10_q <= (w10_raw == '0) ? 12'd1 : w10_raw;
			if (cfg_we) begin
				case (cfg_index)
					REG_PIXEL_FORMAT: fmt_q    <= cfg_data[1:0];
					REG_WIDTH_PIXELS: width_q  <= cfg_data;
					REG_HEIGHT_LINES: height_q <= cfg_data;
					REG_SCROLL_STEP:  step_q   <= cfg_data[5:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		if (width_q == '0) w_eff = 12'd1;
		else if ({1'b0, width_q} > MAX_WIDTH) w_eff = MAX_WIDTH[11:0];
		else w_eff = width_q;
	end

	assign h_eff    = (height_q == '0) ? 12'd1 : height_q;
	assign w10_prod = {21'b0, w_eff} * {12'b0, W10_RECIP};
	assign w10_raw  = w10_prod[W10_SHIFT +: 12];

	assign cfg.fmt    = fmt_q;
	assign cfg.width  = w_eff;
	assign cfg.height = h_eff;
	assign cfg.w10    = w10_q;
	assign cfg.step   = step_q;

	stpg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.push     (q_push),
		.push_item(push_item),
		.q_full   (q_full)
	);

	stpg_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (q_pop),
		.pop_item (pop_item),
		.empty    (q_empty)
	);

	stpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_empty     (q_empty),
		.pop         (q_pop),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.chan_a      (chan_a),
		.chan_b      (chan_b),
		.chan_c      (chan_c),
		.end_of_line (end_of_line),
		.end_of_frame(end_of_frame)
	);

	`STPG_ASSERT_IMPL(a_push_not_full, q_push, !q_full)
	`STPG_ASSERT_IMPL(a_pop_not_empty, q_pop, !q_empty)
	`STPG_ASSERT_NEXT(a_single_pop, q_pop, !q_pop)
	`STPG_ASSERT_IMPL(a_eof_has_eol, out_valid && end_of_frame, end_of_line)

endmodule

// ===== tb/scrolling_test_pattern_generator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scrolling test pattern generator: self-checking testbench
// Walks a short plan of register writes and requests with known pixels,
// then random phases of frame geometry, format and scroll step with idle
// and stall on both channels. A pixel predictor tracks position and scroll
// offset; each pixel is compared in order against it or a planned value.
// ----------------------------------------------------------------------------
module scrolling_test_pattern_generator_unit_test;
	import stpg_pkg::*;

	localparam logic [1:0] FMT_NONE = 2'd3;
	localparam int RANDOM_REQUESTS = 1900;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic       end_of_line;
		logic       end_of_frame;
	} pixel_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_PIXEL
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  index;
		logic [11:0] data;
		logic        restart;
		bit          known;
		pixel_t      pixel;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_PIXEL_FORMAT;
	logic [11:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  chan_a;
	logic [7:0]  chan_b;
	logic [7:0]  chan_c;
	logic        end_of_line;
	logic        end_of_frame;

	bit     known_en = 1'b0;
	pixel_t known_pixel = '0;

	logic [1:0]  reg_fmt = FMT_RST;
	logic [11:0] reg_width = WIDTH_RST;
	logic [11:0] reg_height = HEIGHT_RST;
	logic [5:0]  reg_step = STEP_RST;
	logic [11:0] pix_col = '0;
	logic [11:0] pix_row = '0;
	logic [11:0] scroll_off = 12'(STEP_RST % WIDTH_RST);

	pixel_t    expected_pixels[$];
	plan_row_t plan[$];
	int        requests_sent = 0;
	int        pixels_seen = 0;
	int        errors = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        hold_asked = 0;
	int        hold_taken = 0;
	int        hold_left = 0;
	int        cycle_count = 0;

	scrolling_test_pattern_generator_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chan_a(chan_a),
		.chan_b(chan_b),
		.chan_c(chan_c),
		.end_of_line(end_of_line),
		.end_of_frame(end_of_frame)
	);

	always #6 clk = ~clk;

	function automatic int unsigned hue_term(input int unsigned x);
		return (255 * x) >> 16;
	endfunction

	function automatic int unsigned clamp_double(input int unsigned x);
		return (x > 127 ? 127 : x) * 2;
	endfunction

	function automatic pixel_t render_pixel(input logic rst);
		int unsigned w, h, c, w10, v, r, g, bl;
		pixel_t px;
		w = (reg_width == 0) ? 1 : reg_width;
		h = (reg_height == 0) ? 1 : reg_height;
		if (rst) begin
			pix_col = '0;
			pix_row = '0;
			scroll_off = 12'(reg_step % w);
		end
		c = ((pix_col % w) + (scroll_off % w)) % w;
		px = '0;
		r = 0;
		g = 0;
		bl = 0;
		case (reg_fmt)
			FMT_GRAY: begin
				w10 = w / STRIPE_COUNT;
				if (w10 == 0)
					w10 = 1;
				px.chan_a = 8'((255 * (c % w10)) / w10);
			end
			FMT_RGB, FMT_BGR: begin
				v = (c << 16) / w;
				if (v < Q_T1) begin
					r = (3 * v < Q_ONE) ? hue_term(Q_ONE - 3 * v) : 0;
					g = hue_term(3 * v);
				end else if (v < Q_T2) begin
					g = hue_term(3 * (Q_T2 - v));
					bl = hue_term(3 * (v - Q_T1));
				end else begin
					r = hue_term(3 * (v - Q_T2));
					bl = (v < Q_ONE) ? hue_term(3 * (Q_ONE - v)) : 0;
				end
				r = clamp_double(r);
				g = clamp_double(g);
				bl = clamp_double(bl);
				px.chan_b = 8'(g);
				px.chan_a = (reg_fmt == FMT_RGB) ? 8'(r) : 8'(bl);
				px.chan_c = (reg_fmt == FMT_RGB) ? 8'(bl) : 8'(r);
			end
			default: ;
		endcase
		px.end_of_line = (pix_col + 1 >= w);
		px.end_of_frame = px.end_of_line && (pix_row + 1 >= h);
		if (px.end_of_line) begin
			pix_col = '0;
			if (px.end_of_frame) begin
				pix_row = '0;
				scroll_off = 12'(((scroll_off % w) + reg_step) % w);
			end else begin
				pix_row = pix_row + 1;
			end
		end else begin
			pix_col = pix_col + 1;
		end
		return px;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		pixel_t want;
		pixel_t px;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				pixels_seen++;
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected pixel, expected none, actual %0d %0d %0d %0b %0b",
						$time, chan_a, chan_b, chan_c, end_of_line, end_of_frame);
				end else begin
					want = expected_pixels.pop_front();
					check_field("chan_a", want.chan_a, chan_a);
					check_field("chan_b", want.chan_b, chan_b);
					check_field("chan_c", want.chan_c, chan_c);
					check_field("end_of_line", want.end_of_line, end_of_line);
					check_field("end_of_frame", want.end_of_frame, end_of_frame);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PIXEL_FORMAT: reg_fmt = cfg_data[1:0];
					REG_WIDTH_PIXELS: reg_width = cfg_data;
					REG_HEIGHT_LINES: reg_height = cfg_data;
					REG_SCROLL_STEP:  reg_step = cfg_data[5:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				px = render_pixel(restart);
				expected_pixels.push_back(known_en ? known_pixel : px);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void plan_write(input logic [1:0] index, input logic [11:0] data);
		plan.push_back('{ROW_WRITE, index, data, 1'b0, 1'b0, '0});
	endfunction

	function automatic void plan_pixel(input logic rst);
		plan.push_back('{ROW_PIXEL, REG_PIXEL_FORMAT, '0, rst, 1'b0, '0});
	endfunction

	function automatic void plan_known(input logic rst, input pixel_t px);
		plan.push_back('{ROW_PIXEL, REG_PIXEL_FORMAT, '0, rst, 1'b1, px});
	endfunction

	task automatic wait_idle();
		if (in_valid)
			in_valid <= 1'b0;
		while (pixels_seen < requests_sent)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [11:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic push_pixel(input logic rst, input bit known, input pixel_t px);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < idle_pct)
			gap++;
		cfg_we <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rst;
		known_en <= known;
		known_pixel <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	initial begin : stimulus
		int          phase;
		int          random_sent;
		int          phase_len;
		int          pick;
		logic [11:0] cur_width;
		phase = 0;
		random_sent = 0;
		cur_width = WIDTH_RST;

		plan_known(1'b0, '{8'd254, 8'd4, 8'd0, 1'b0, 1'b0});
		plan_known(1'b1, '{8'd254, 8'd4, 8'd0, 1'b0, 1'b0});
		plan_write(REG_PIXEL_FORMAT, 12'(FMT_BGR));
		plan_known(1'b1, '{8'd0, 8'd4, 8'd254, 1'b0, 1'b0});
		plan_write(REG_PIXEL_FORMAT, 12'(FMT_NONE));
		plan_known(1'b0, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0});
		plan_write(REG_WIDTH_PIXELS, 12'd0);
		plan_write(REG_HEIGHT_LINES, 12'd0);
		plan_known(1'b0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1});
		plan_write(REG_PIXEL_FORMAT, 12'(FMT_GRAY));
		plan_known(1'b0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1});
		plan_known(1'b1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1});
		plan_write(REG_WIDTH_PIXELS, 12'd5);
		plan_write(REG_HEIGHT_LINES, 12'd2);
		plan_known(1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0});
		repeat (5) plan_pixel(1'b0);
		plan_write(REG_WIDTH_PIXELS, 12'd4095);
		plan_write(REG_HEIGHT_LINES, 12'd4095);
		plan_write(REG_SCROLL_STEP, 12'd60);
		plan_pixel(1'b1);
		plan_pixel(1'b0);
		plan_write(REG_PIXEL_FORMAT, 12'(FMT_RGB));
		plan_pixel(1'b1);
		plan_write(REG_WIDTH_PIXELS, 12'd10);
		repeat (3) plan_pixel(1'b0);
		plan_known(1'b1, '{8'd254, 8'd0, 8'd0, 1'b0, 1'b0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].index, plan[i].data);
			else
				push_pixel(plan[i].restart, plan[i].known, plan[i].pixel);
		end

		while (random_sent < RANDOM_REQUESTS) begin
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 46; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 46; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			if (phase < 4 || $urandom_range(1) == 1) begin
				pick = $urandom_range(99);
				write_reg(REG_PIXEL_FORMAT,
					{10'($urandom), (pick < 10) ? FMT_NONE : 2'($urandom_range(2))});
			end
			if (phase < 4 || $urandom_range(1) == 1) begin
				pick = $urandom_range(99);
				if (pick < 8)
					cur_width = 12'($urandom_range(9));
				else if (pick < 14)
					cur_width = 12'd4095;
				else if (pick < 20)
					cur_width = 12'($urandom_range(1000, 41));
				else
					cur_width = 12'($urandom_range(40, 10));
				write_reg(REG_WIDTH_PIXELS, cur_width);
			end
			if (phase < 4 || $urandom_range(1) == 1) begin
				pick = $urandom_range(99);
				if (pick < 8)
					write_reg(REG_HEIGHT_LINES, 12'd0);
				else if (pick < 12)
					write_reg(REG_HEIGHT_LINES, 12'd4095);
				else
					write_reg(REG_HEIGHT_LINES, 12'($urandom_range(5, 1)));
			end
			if (phase < 4 || $urandom_range(1) == 1)
				write_reg(REG_SCROLL_STEP, {6'($urandom), 6'($urandom_range(63))});
			if (phase % 12 == 2)
				hold_asked++;
			phase_len = (cur_width > 12'd1000) ? 25 : $urandom_range(90, 30);
			repeat (phase_len) begin
				push_pixel($urandom_range(99) < 4, 1'b0, '0);
				random_sent++;
			end
			wait_idle();
			phase++;
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_pixels.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
